// ----- rtl/assert_macros.svh -----
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge, switched off while in reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, with no reset qualifier.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/mcema_pkg.sv -----
package mcema_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int FACTOR_W  = 16;
    localparam int GAIN_W    = 16;
    localparam int NCH_W     = 5;
    localparam int CHAN_W    = 4;
    localparam int CFG_IDX_W = 2;

    // datapath widths
    localparam int WEIGHT_W = FACTOR_W + 1;
    localparam int P1_W     = SAMPLE_W + WEIGHT_W;
    localparam int P2_W     = SAMPLE_W + WEIGHT_W + 1;
    localparam int P3_W     = P2_W + GAIN_W + 1;
    localparam int ACC_W    = P3_W + 1;
    localparam int Q_W      = ACC_W - 24;

    localparam logic [WEIGHT_W-1:0]     ONE_Q16  = WEIGHT_W'(65536);
    localparam logic signed [ACC_W-1:0] HALF_Q24 = ACC_W'(64'sd8388608);

    localparam logic [CFG_IDX_W-1:0] REG_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NCH    = 2'd2;

    localparam logic ACT_FILTER = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_FIN
    } st_t;

    typedef struct packed {
        logic accept;
        logic mul1;
        logic mul2;
        logic fin;
    } ctrl_t;

endpackage

// ----- rtl/mcema_state_mem.sv -----
`include "assert_macros.svh"

module mcema_state_mem
    import mcema_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output logic [SAMPLE_W-1:0] rd_data,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic [SAMPLE_W-1:0] wr_data
);

    logic [SAMPLE_W-1:0] store_mem [DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                rd_hit_reg;
    logic                rd_hit_next;
    logic [DEPTH-1:0]    valid_reg;
    logic [DEPTH-1:0]    valid_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // entries not written since the last clear read as zero
    always_comb
    begin
        valid_next = valid_reg;
        if (clear)
        begin
            valid_next = '0;
        end
        else if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
        rd_hit_next = ({1'b0, rd_addr} < (AW + 1)'(DEPTH)) ? valid_reg[rd_addr] : 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_en)
            begin
                rd_hit_reg <= rd_hit_next;
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

    `ASSERT_AT(a_wr_sets_valid, clk, rst_n, wr_en && !clear |=> valid_reg[$past(wr_addr)], "written entry not marked valid")

endmodule

// ----- rtl/mcema_ctrl.sv -----
`include "assert_macros.svh"

module mcema_ctrl
    import mcema_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  logic  out_valid,
    input  logic  out_stall,
    output ctrl_t ctrl
);

    st_t state_reg;
    st_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_MUL;
            ST_MUL:  state_next = ST_FIN;
            ST_FIN:
            begin
                if (!out_valid || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall    = (state_reg != ST_IDLE);
        ctrl.accept = (state_reg == ST_IDLE) && in_valid;
        ctrl.mul1   = (state_reg == ST_READ);
        ctrl.mul2   = (state_reg == ST_MUL);
        ctrl.fin    = (state_reg == ST_FIN) && (!out_valid || !out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `ASSERT_AT(a_acc_to_read, clk, rst_n, ctrl.accept |=> state_reg == ST_READ, "accepted beat did not start a read")
    `ASSERT_AT(a_fin_no_overwrite, clk, rst_n, ctrl.fin |-> !(out_valid && out_stall), "result overwrites a held beat")

endmodule

// ----- rtl/mcema_datapath.sv -----
`include "assert_macros.svh"

module mcema_datapath
    import mcema_pkg::*;
#(
    parameter int CHANNELS    = 16,
    parameter int SAMPLE_BITS = 16,
    parameter int AW          = 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  ctrl_t                      ctrl,
    input  logic                       action,
    input  logic [CHAN_W-1:0]          channel,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [FACTOR_W-1:0]        factor,
    input  logic [GAIN_W-1:0]          gain,
    input  logic [NCH_W-1:0]           nch,
    input  logic [SAMPLE_W-1:0]        rd_data,
    output logic                       wr_en,
    output logic [AW-1:0]              wr_addr,
    output logic [SAMPLE_W-1:0]        wr_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [CHAN_W-1:0]          out_channel,
    output logic signed [SAMPLE_W-1:0] filtered,
    output logic                       saturated,
    output logic                       bad_channel
);

    localparam int EFF_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam logic signed [Q_W-1:0] MAXV = Q_W'((64'sd1 <<< (EFF_BITS - 1)) - 64'sd1);
    localparam logic signed [Q_W-1:0] MINV = -MAXV - Q_W'(1);
    localparam logic [8:0] CH_LIM = 9'(CHANNELS);

    logic                       act_reg;
    logic [CHAN_W-1:0]          chan_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic                       bad_reg;
    logic signed [P1_W-1:0]     p1_reg;
    logic signed [P2_W-1:0]     p2_reg;
    logic signed [P3_W-1:0]     p3_reg;
    logic                       out_valid_reg;
    logic [CHAN_W-1:0]          out_channel_reg;
    logic signed [SAMPLE_W-1:0] filtered_reg;
    logic                       saturated_reg;
    logic                       bad_channel_reg;

    logic                       bad_in;
    logic signed [SAMPLE_W-1:0] x_in;
    logic [WEIGHT_W-1:0]        b_weight;
    logic signed [P1_W-1:0]     p1_next;
    logic signed [P2_W-1:0]     p2_next;
    logic signed [P3_W-1:0]     p3_next;
    logic signed [ACC_W-1:0]    acc;
    logic signed [Q_W-1:0]      q_raw;
    logic signed [SAMPLE_W-1:0] q_sat;
    logic                       sat;
    logic                       write_back;

    always_comb
    begin
        bad_in   = ({1'b0, channel} >= nch) || ({5'b0, channel} >= CH_LIM);
        x_in     = SAMPLE_W'($signed(sample[EFF_BITS-1:0]));
        b_weight = ONE_Q16 - {1'b0, factor};
        p1_next  = $signed(rd_data) * $signed({1'b0, factor});
        p2_next  = x_reg * $signed({1'b0, b_weight});
        p3_next  = p2_reg * $signed({1'b0, gain});
        // Q.24 sum, round half up, floor by arithmetic shift
        acc      = ($signed(ACC_W'(p1_reg)) <<< 8) + $signed(ACC_W'(p3_reg)) + HALF_Q24;
        q_raw    = acc[ACC_W-1:24];
        priority if (q_raw > MAXV)
        begin
            q_sat = SAMPLE_W'(MAXV);
            sat   = 1'b1;
        end
        else if (q_raw < MINV)
        begin
            q_sat = SAMPLE_W'(MINV);
            sat   = 1'b1;
        end
        else
        begin
            q_sat = q_raw[SAMPLE_W-1:0];
            sat   = 1'b0;
        end
        write_back = ctrl.fin && (act_reg == ACT_FILTER) && !bad_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            act_reg  <= action;
            chan_reg <= channel;
            x_reg    <= x_in;
            bad_reg  <= bad_in;
        end
        if (ctrl.mul1)
        begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
        if (ctrl.mul2)
        begin
            p3_reg <= p3_next;
        end
        if (ctrl.fin)
        begin
            out_channel_reg <= chan_reg;
            bad_channel_reg <= (act_reg == ACT_FILTER) && bad_reg;
            filtered_reg    <= write_back ? q_sat : '0;
            saturated_reg   <= write_back && sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.fin)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign wr_en       = write_back;
    assign wr_addr     = AW'(chan_reg);
    assign wr_data     = q_sat;
    assign out_valid   = out_valid_reg;
    assign out_channel = out_channel_reg;
    assign filtered    = filtered_reg;
    assign saturated   = saturated_reg;
    assign bad_channel = bad_channel_reg;

    `ASSERT_AT(a_bad_zero, clk, rst_n, out_valid && bad_channel |-> filtered == '0 && !saturated, "bad channel beat carries data")

endmodule

// ----- rtl/multichannel_ema_lowpass_top.sv -----
// A result beat is registered after the state memory read, two multiply stages
// and a round/saturate/write-back stage on one shared datapath. A new input beat
// is accepted only once the last has finished; the last stage waits on out_stall.
// Reset (rst_n low, asynchronous): factor 58982, gain 256, one channel, all
// channel states read as zero, no result pending.
module multichannel_ema_lowpass_top
    import mcema_pkg::*;
#(
    parameter int CHANNELS    = 16,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       action,
    input  logic [CHAN_W-1:0]          channel,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [CHAN_W-1:0]          out_channel,
    output logic signed [SAMPLE_W-1:0] filtered,
    output logic                       saturated,
    output logic                       bad_channel,
    input  logic                       wr_en,
    input  logic [CFG_IDX_W-1:0]       wr_index,
    input  logic [FACTOR_W-1:0]        wr_data
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [FACTOR_W-1:0] factor_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [NCH_W-1:0]    nch_reg;

    ctrl_t               ctrl;
    logic                cfg_clear;
    logic                mem_clear;
    logic [SAMPLE_W-1:0] rd_data;
    logic                mem_wr_en;
    logic [AW-1:0]       mem_wr_addr;
    logic [SAMPLE_W-1:0] mem_wr_data;

    assign cfg_clear = wr_en && ((wr_index == REG_FACTOR) || (wr_index == REG_GAIN) ||
                                 (wr_index == REG_NCH));
    assign mem_clear = cfg_clear || (ctrl.accept && (action == ACT_CLEAR));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= FACTOR_W'(58982);
            gain_reg   <= GAIN_W'(256);
            nch_reg    <= NCH_W'(1);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_FACTOR: factor_reg <= wr_data;
                REG_GAIN:   gain_reg   <= wr_data[GAIN_W-1:0];
                REG_NCH:    nch_reg    <= wr_data[NCH_W-1:0];
                default:    ;
            endcase
        end
    end

    mcema_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctrl      (ctrl)
    );

    mcema_state_mem #(
        .DEPTH (CHANNELS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (mem_clear),
        .rd_en   (ctrl.accept),
        .rd_addr (AW'(channel)),
        .rd_data (rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    mcema_datapath #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .AW          (AW)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .action      (action),
        .channel     (channel),
        .sample      (sample),
        .factor      (factor_reg),
        .gain        (gain_reg),
        .nch         (nch_reg),
        .rd_data     (rd_data),
        .wr_en       (mem_wr_en),
        .wr_addr     (mem_wr_addr),
        .wr_data     (mem_wr_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_channel (out_channel),
        .filtered    (filtered),
        .saturated   (saturated),
        .bad_channel (bad_channel)
    );

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    import mcema_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct {
        logic                       act;
        logic [CHAN_W-1:0]          ch;
        logic signed [SAMPLE_W-1:0] x;
    } beat_t;

    typedef struct {
        logic [CHAN_W-1:0]          ch;
        logic signed [SAMPLE_W-1:0] y;
        logic                       sat;
        logic                       bad;
    } ema_res_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       action = ACT_FILTER;
    logic [CHAN_W-1:0]          channel = '0;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [CHAN_W-1:0]          out_channel;
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       saturated;
    logic                       bad_channel;
    logic                       wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]       wr_index = '0;
    logic [FACTOR_W-1:0]        wr_data = '0;

    beat_t    pending_beats[$];
    ema_res_t due_results[$];

    // predictor state
    logic [FACTOR_W-1:0]        factor_sh = 16'd58982;
    logic [GAIN_W-1:0]          gain_sh = 16'd256;
    logic [NCH_W-1:0]           nch_sh = 5'd1;
    logic signed [SAMPLE_W-1:0] chan_state[16];

    int  errors = 0;
    int  run_cycles = 0;
    int  gap_left = 0;
    int  stall_hold = 0;
    bit  calm = 1'b0;

    multichannel_ema_lowpass_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .channel    (channel),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_channel(out_channel),
        .filtered   (filtered),
        .saturated  (saturated),
        .bad_channel(bad_channel),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic ema_res_t ema_step(input logic act, input logic [CHAN_W-1:0] ch,
                                          input logic signed [SAMPLE_W-1:0] x);
        ema_res_t r;
        int       lim;
        longint   a;
        longint   b;
        longint   acc;
        longint   q;
        r.ch  = ch;
        r.y   = '0;
        r.sat = 1'b0;
        r.bad = 1'b0;
        lim = (nch_sh > 16) ? 16 : int'(nch_sh);
        if (act == ACT_CLEAR)
        begin
            foreach (chan_state[i])
                chan_state[i] = '0;
        end
        else if (int'(ch) >= lim)
        begin
            r.bad = 1'b1;
        end
        else
        begin
            a   = longint'(factor_sh);
            b   = 65536 - a;
            acc = longint'(chan_state[ch]) * a * 256 + longint'(x) * b * longint'(gain_sh);
            q   = (acc + 64'sd8388608) >>> 24;
            if (q > 32767)
            begin
                q = 32767;
                r.sat = 1'b1;
            end
            else if (q < -32768)
            begin
                q = -32768;
                r.sat = 1'b1;
            end
            chan_state[ch] = SAMPLE_W'(q);
            r.y = SAMPLE_W'(q);
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin : drive_beats
        beat_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                due_results.push_back(ema_step(action, channel, sample));
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_beats.size() > 0)
                begin
                    nxt = pending_beats.pop_front();
                    in_valid <= 1'b1;
                    action   <= nxt.act;
                    channel  <= nxt.ch;
                    sample   <= nxt.x;
                    gap_left <= pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin : watch_results
        ema_res_t e;
        int       r;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_hold <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result beat with nothing expected (channel %0d)", out_channel);
                    errors++;
                end
                else
                begin
                    e = due_results.pop_front();
                    if (out_channel !== e.ch)
                    begin
                        $error("out_channel: expected %0d, got %0d", e.ch, out_channel);
                        errors++;
                    end
                    if (filtered !== e.y)
                    begin
                        $error("filtered: expected %0d, got %0d", e.y, filtered);
                        errors++;
                    end
                    if (saturated !== e.sat)
                    begin
                        $error("saturated: expected %0b, got %0b", e.sat, saturated);
                        errors++;
                    end
                    if (bad_channel !== e.bad)
                    begin
                        $error("bad_channel: expected %0b, got %0b", e.bad, bad_channel);
                        errors++;
                    end
                end
            end
            if (stall_hold > 0)
            begin
                stall_hold <= stall_hold - 1;
            end
            else if (calm)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                out_stall  <= (r < 30);
                stall_hold <= (r < 25) ? $urandom_range(0, 2) :
                              (r < 30) ? $urandom_range(5, 25) : $urandom_range(0, 6);
            end
        end
    end

    always @(posedge clk)
    begin
        run_cycles <= run_cycles + 1;
        if (run_cycles > CYCLE_LIMIT)
        begin
            $display("** multichannel_ema_lowpass_top: FAILED **");
            $finish;
        end
    end

    task automatic add_beat(input logic act, input int ch, input int x);
        beat_t b;
        b.act = act;
        b.ch  = CHAN_W'(ch);
        b.x   = SAMPLE_W'(x);
        pending_beats.push_back(b);
    endtask

    task automatic wait_idle();
        while (pending_beats.size() != 0 || in_valid || due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FACTOR_W-1:0] val);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        case (idx)
            REG_FACTOR: factor_sh = val;
            REG_GAIN:   gain_sh = val;
            REG_NCH:    nch_sh = val[NCH_W-1:0];
            default:    ;
        endcase
        if (idx != REG_SPARE)
        begin
            foreach (chan_state[i])
                chan_state[i] = '0;
        end
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    function automatic int rand_sample();
        case ($urandom_range(0, 9))
            0:       return 32767;
            1:       return -32768;
            2:       return int'($urandom_range(0, 16)) - 8;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    initial
    begin : stimulus
        int lim;
        int ch;
        foreach (chan_state[i])
            chan_state[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: one channel, a about 0.9, unity gain
        add_beat(ACT_FILTER, 0, 32767);
        add_beat(ACT_FILTER, 0, 32767);
        add_beat(ACT_FILTER, 0, -32768);
        add_beat(ACT_FILTER, 0, 1);
        add_beat(ACT_FILTER, 0, -1);
        add_beat(ACT_FILTER, 1, 100);
        add_beat(ACT_FILTER, 15, -5);
        add_beat(ACT_CLEAR, 7, 1234);
        add_beat(ACT_FILTER, 0, 0);
        wait_idle();

        // zero factor, full gain: saturation both ways
        write_reg(REG_NCH, {11'h5a5, 5'd16});
        write_reg(REG_FACTOR, 16'd0);
        write_reg(REG_GAIN, 16'hffff);
        add_beat(ACT_FILTER, 15, 32767);
        add_beat(ACT_FILTER, 3, -32768);
        add_beat(ACT_FILTER, 3, 1);
        add_beat(ACT_FILTER, 15, -1);
        add_beat(ACT_FILTER, 8, 0);
        wait_idle();

        // heaviest smoothing, tiny gain; spare index must keep the state
        write_reg(REG_FACTOR, 16'hffff);
        write_reg(REG_GAIN, 16'd1);
        add_beat(ACT_FILTER, 15, 32767);
        wait_idle();
        write_reg(REG_SPARE, 16'($urandom()));
        add_beat(ACT_FILTER, 15, -32768);
        wait_idle();

        // no channels in use
        write_reg(REG_NCH, 16'd0);
        add_beat(ACT_FILTER, 0, 5);
        add_beat(ACT_FILTER, 15, 5);
        wait_idle();

        // oversized count, rounding at exactly one half
        write_reg(REG_NCH, 16'd31);
        write_reg(REG_FACTOR, 16'd32768);
        write_reg(REG_GAIN, 16'd256);
        add_beat(ACT_FILTER, 15, 1);
        add_beat(ACT_FILTER, 4, -1);
        add_beat(ACT_FILTER, 15, -1);
        add_beat(ACT_CLEAR, 0, -32768);
        wait_idle();

        for (int ph = 0; ph < 6; ph++)
        begin
            calm = (ph == 2);
            case ($urandom_range(0, 4))
                0:       write_reg(REG_FACTOR, 16'($urandom_range(0, 65535)));
                1:       write_reg(REG_FACTOR, 16'hffff);
                2:       write_reg(REG_FACTOR, 16'd0);
                default: write_reg(REG_FACTOR, 16'($urandom_range(50000, 65535)));
            endcase
            case ($urandom_range(0, 3))
                0:       write_reg(REG_GAIN, 16'd256);
                1:       write_reg(REG_GAIN, 16'($urandom_range(0, 65535)));
                2:       write_reg(REG_GAIN, 16'($urandom_range(128, 1024)));
                default: write_reg(REG_GAIN, 16'hffff);
            endcase
            if ($urandom_range(0, 99) < 80)
                write_reg(REG_NCH, {11'($urandom()), 5'($urandom_range(1, 16))});
            else
                write_reg(REG_NCH, {11'($urandom()), 5'($urandom_range(0, 31))});
            lim = (nch_sh > 16) ? 16 : int'(nch_sh);
            for (int i = 0; i < 75; i++)
            begin
                if ($urandom_range(0, 99) < 85 && lim > 0)
                    ch = $urandom_range(0, lim - 1);
                else
                    ch = $urandom_range(0, 15);
                if ($urandom_range(0, 99) < 5)
                    add_beat(ACT_CLEAR, ch, rand_sample());
                else
                    add_beat(ACT_FILTER, ch, rand_sample());
            end
            wait_idle();
        end

        calm = 1'b0;
        repeat (10) @(posedge clk);
        if (errors == 0 && due_results.size() == 0)
            $display("** multichannel_ema_lowpass_top: PASSED **");
        else
            $display("** multichannel_ema_lowpass_top: FAILED **");
        $finish;
    end

endmodule
